[design/lppfp_pkg.sv]
// Package for the length-prefixed point frame parser.
// Holds the channel payload types, the result kinds, the parser phase codes
// and the fixed framing constants. Depends on nothing.
package lppfp_pkg;

    // Framing constants
    localparam int unsigned WORD_BYTES  = 4;
    localparam int unsigned POINT_BYTES = 8;
    localparam logic [7:0]  TERMINATOR  = 8'h00;
    localparam logic [1:0]  HDR_LAST    = 2'(WORD_BYTES - 1);
    localparam logic [2:0]  PT_LAST     = 3'(POINT_BYTES - 1);

    // Kind of a result transaction
    typedef enum logic [1:0] {
        KIND_ID    = 2'd0,
        KIND_POINT = 2'd1,
        KIND_END   = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_IDENT  = 3'b010,
        PH_POINTS = 3'b100
    } phase_t;

    // Payload of an input transaction
    typedef struct packed {
        logic [7:0] stream_byte;
    } in_item_t;

    // Payload of a result transaction
    typedef struct packed {
        kind_t              kind;
        logic [7:0]         id_char;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               frame_last;
    } result_t;

    // Hand-over control from the step logic to the two stage registers
    typedef struct packed {
        logic advance;
        logic load;
    } step_ctrl_t;

endpackage

[design/lppfp_chan_if.sv]
// Valid/ready channel interface used for both ports of the parser.
// The payload type is a parameter; the types come from lppfp_pkg.
interface lppfp_chan_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/lppfp_in_stage.sv]
// Input register of the parser: holds one accepted stream byte until the
// step logic consumes it. Depends on lppfp_pkg.
module lppfp_in_stage
    import lppfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  in_item_t   in_data,
    output logic       in_ready,
    input  step_ctrl_t ctrl,
    output logic       item_valid,
    output logic [7:0] item_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register frees up in the same cycle that its byte moves on.
    assign in_ready = !valid_reg || ctrl.advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (ctrl.advance)
        begin
            valid_next = 1'b0;
        end
    end

    // Control flag under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_data.stream_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

[design/lppfp_step.sv]
// Frame state and single-pass decode of one stream byte per cycle, while the output can take any result.
// Holds phase, length countdown and assembly shift register.
// Depends on lppfp_pkg.
module lppfp_step
    import lppfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [7:0] item_byte,
    input  logic       out_free,
    output step_ctrl_t ctrl,
    output result_t    res
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [31:0] bytes_left_reg;
    logic [31:0] bytes_left_next;
    logic [1:0]  header_count_reg;
    logic [1:0]  header_count_next;
    logic [63:0] assembly_reg;
    logic [63:0] assembly_next;
    logic [2:0]  point_count_reg;
    logic [2:0]  point_count_next;

    logic        has_result;
    logic [31:0] left_dec;
    logic        left_zero;
    logic [63:0] point_shift;
    logic [31:0] header_word;

    // Shared arithmetic on the current byte.
    assign left_dec    = bytes_left_reg - 32'd1;
    assign left_zero   = (left_dec == 32'd0);
    assign point_shift = {assembly_reg[55:0], item_byte};
    assign header_word = {assembly_reg[23:0], item_byte};

    // Next state and result for the byte in the input register.
    always_comb
    begin
        phase_next        = phase_reg;
        bytes_left_next   = bytes_left_reg;
        header_count_next = header_count_reg;
        assembly_next     = assembly_reg;
        point_count_next  = point_count_reg;
        has_result        = 1'b0;
        res.kind          = KIND_ID;
        res.id_char       = 8'h00;
        res.point_x       = '0;
        res.point_y       = '0;
        res.frame_last    = 1'b0;

        case (phase_reg)
            PH_IDENT:
            begin
                bytes_left_next = left_dec;
                if (item_byte != TERMINATOR)
                begin
                    has_result = 1'b1;
                    if (left_zero)
                    begin
                        // Identifier ran to the frame end with no terminator.
                        res.kind       = KIND_ERROR;
                        res.frame_last = 1'b1;
                    end
                    else
                    begin
                        res.kind    = KIND_ID;
                        res.id_char = item_byte;
                    end
                end
                else if (left_zero)
                begin
                    has_result     = 1'b1;
                    res.kind       = KIND_END;
                    res.frame_last = 1'b1;
                end
                else
                begin
                    phase_next       = PH_POINTS;
                    assembly_next    = '0;
                    point_count_next = '0;
                end
            end

            PH_POINTS:
            begin
                bytes_left_next = left_dec;
                assembly_next   = point_shift;
                if (point_count_reg == PT_LAST)
                begin
                    has_result       = 1'b1;
                    res.kind         = KIND_POINT;
                    res.point_x      = signed'(point_shift[63:32]);
                    res.point_y      = signed'(point_shift[31:0]);
                    res.frame_last   = left_zero;
                    point_count_next = '0;
                    assembly_next    = '0;
                end
                else
                begin
                    point_count_next = point_count_reg + 3'd1;
                    if (left_zero)
                    begin
                        // Partial point at the frame end is dropped.
                        has_result     = 1'b1;
                        res.kind       = KIND_END;
                        res.frame_last = 1'b1;
                    end
                end
            end

            default:
            begin
                // Header, and any code outside the one-hot set.
                phase_next    = PH_HEADER;
                assembly_next = {32'h0, header_word};
                if (header_count_reg == HDR_LAST)
                begin
                    header_count_next = '0;
                    assembly_next     = '0;
                    if ((header_word == 32'd0) || header_word[31])
                    begin
                        has_result     = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.frame_last = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next  = header_word;
                        phase_next       = PH_IDENT;
                        point_count_next = '0;
                    end
                end
                else
                begin
                    header_count_next = header_count_reg + 2'd1;
                end
            end
        endcase

        // Every closing result sends the parser back to the header.
        if (has_result && res.frame_last)
        begin
            phase_next        = PH_HEADER;
            bytes_left_next   = '0;
            header_count_next = '0;
            assembly_next     = '0;
            point_count_next  = '0;
        end
    end

    // A byte moves on unless it makes a result that the output cannot take.
    assign ctrl.advance = item_valid && (!has_result || out_free);
    assign ctrl.load    = item_valid && has_result && out_free;

    // State registers, updated only as a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            bytes_left_reg   <= '0;
            header_count_reg <= '0;
            assembly_reg     <= '0;
            point_count_reg  <= '0;
        end
        else if (ctrl.advance)
        begin
            phase_reg        <= phase_next;
            bytes_left_reg   <= bytes_left_next;
            header_count_reg <= header_count_next;
            assembly_reg     <= assembly_next;
            point_count_reg  <= point_count_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The phase register stays one-hot.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_reg))
        else $error("parser phase is not one-hot");

    // A closing result always returns the parser to the header phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.load && res.frame_last) |=> (phase_reg == PH_HEADER))
        else $error("frame closed but parser did not return to header");

    // Header byte count is only ever non-zero while taking a header.
    assert property (@(posedge clk) disable iff (!rst_n)
        (header_count_reg != 2'd0) |-> (phase_reg == PH_HEADER))
        else $error("header count set outside the header phase");

    // Nothing advances without a byte present.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance |-> item_valid)
        else $error("step advanced with an empty input register");
`endif

endmodule

[design/lppfp_out_stage.sv]
// Output register of the parser: holds one result transaction until the
// receiver takes it. Depends on lppfp_pkg.
module lppfp_out_stage
    import lppfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_ctrl_t ctrl,
    input  result_t    res,
    output logic       out_free,
    output logic       out_valid,
    output result_t    out_data,
    input  logic       out_ready
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The register can be reloaded in the cycle that its result is taken.
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Control flag under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/length_prefixed_point_frame_parser.sv]
// Length-prefixed point frame parser, top level.
// Uses lppfp_pkg, lppfp_chan_if, lppfp_in_stage, lppfp_step, lppfp_out_stage.
//
// Usage:
//   stream : sink channel, one received byte per transaction.
//   result : source channel, at most one result transaction per byte:
//            identifier byte, assembled x,y point, frame end, or framing
//            error; frame_last marks the result that closes a frame.
// Each frame is a 4-byte big-endian length, a zero-terminated identifier
// and big-endian 32-bit x,y pairs. A non-positive length, or an identifier
// without terminator, gives an error result and the next byte starts a
// new header.
// Throughput: one byte per cycle while results are taken, set by the
// single-pass step logic between the input register and the result register.
// Path: a byte is accepted into the input register, decoded, and its result
// is loaded into the result register once that register is free.
// Reset: both registers empty, the parser expects a header.
// Stall: while the receiver holds ready low, one result waits in the result
// register and one more byte waits in the input register; further bytes
// are refused until the result is taken. Bytes giving no result still flow.
module length_prefixed_point_frame_parser
    import lppfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lppfp_chan_if.sink   stream,
    lppfp_chan_if.source result
);

    logic       item_valid;
    logic [7:0] item_byte;
    logic       out_free;
    step_ctrl_t ctrl;
    result_t    res;
    in_item_t   in_data;
    result_t    out_data;
    logic       in_ready;
    logic       out_valid;

    assign in_data = stream.data;

    // Input register
    lppfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stream.valid),
        .in_data    (in_data),
        .in_ready   (in_ready),
        .ctrl       (ctrl),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    assign stream.ready = in_ready;

    // Frame state and decode
    lppfp_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .res        (res)
    );

    // Result register
    lppfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (result.ready)
    );

    assign result.valid = out_valid;
    assign result.data  = out_data;

endmodule
